// ===== hw/rtl/alkd_pkg.sv =====
// Shared types and constants for the analog ladder keypad debouncer.
// Used by every module under hw/rtl; has no dependencies of its own.
package alkd_pkg;

    // Field widths
    localparam int TIME_W = 32;
    localparam int RAW_W  = 12;
    localparam int KEY_W  = 3;
    localparam int DEB_W  = 16;
    localparam int NUM_KEYS = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KEY1_MAX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY4_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY5_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY6_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 3'd7;

    // Register reset values
    localparam logic [RAW_W-1:0] KEY1_MAX_RST    = 12'd300;
    localparam logic [RAW_W-1:0] KEY2_MAX_RST    = 12'd800;
    localparam logic [RAW_W-1:0] KEY3_MAX_RST    = 12'd1400;
    localparam logic [RAW_W-1:0] KEY4_MAX_RST    = 12'd2000;
    localparam logic [RAW_W-1:0] KEY5_MAX_RST    = 12'd2600;
    localparam logic [RAW_W-1:0] KEY6_MAX_RST    = 12'd3200;
    localparam logic [RAW_W-1:0] RELEASE_THR_RST = 12'd3700;
    localparam logic [DEB_W-1:0] DEBOUNCE_MS_RST = 16'd30;

    // Minimum spacing between accepted readings, in ms
    localparam logic [TIME_W-1:0] SAMPLE_INTERVAL_MS = 32'd5;

    // Key code meaning no key pressed
    localparam logic [KEY_W-1:0] KEY_NONE = 3'd0;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [RAW_W-1:0]  raw_sample;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] stable_key;
        logic [RAW_W-1:0] held_raw;
        logic             press_valid;
        logic [KEY_W-1:0] press_key;
        logic [RAW_W-1:0] press_raw;
    } t_out_item;

    typedef struct packed {
        logic [NUM_KEYS-1:0][RAW_W-1:0] key_max;
        logic [RAW_W-1:0]               release_thr;
        logic [DEB_W-1:0]               debounce_ms;
    } t_cfg;

endpackage

// ===== hw/rtl/alkd_cfg_regs.sv =====
// Configuration register file for the keypad debouncer.
// Depends on alkd_pkg for register indexes, widths and reset values.
module alkd_cfg_regs
    import alkd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Write-only registers, one per index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_max[0]  <= KEY1_MAX_RST;
            r_cfg.key_max[1]  <= KEY2_MAX_RST;
            r_cfg.key_max[2]  <= KEY3_MAX_RST;
            r_cfg.key_max[3]  <= KEY4_MAX_RST;
            r_cfg.key_max[4]  <= KEY5_MAX_RST;
            r_cfg.key_max[5]  <= KEY6_MAX_RST;
            r_cfg.release_thr <= RELEASE_THR_RST;
            r_cfg.debounce_ms <= DEBOUNCE_MS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_KEY1_MAX:    r_cfg.key_max[0]  <= i_cfg_wdata[RAW_W-1:0];
                REG_KEY2_MAX:    r_cfg.key_max[1]  <= i_cfg_wdata[RAW_W-1:0];
                REG_KEY3_MAX:    r_cfg.key_max[2]  <= i_cfg_wdata[RAW_W-1:0];
                REG_KEY4_MAX:    r_cfg.key_max[3]  <= i_cfg_wdata[RAW_W-1:0];
                REG_KEY5_MAX:    r_cfg.key_max[4]  <= i_cfg_wdata[RAW_W-1:0];
                REG_KEY6_MAX:    r_cfg.key_max[5]  <= i_cfg_wdata[RAW_W-1:0];
                REG_RELEASE_THR: r_cfg.release_thr <= i_cfg_wdata[RAW_W-1:0];
                REG_DEBOUNCE_MS: r_cfg.debounce_ms <= i_cfg_wdata[DEB_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/alkd_decode.sv =====
// Ladder decoder: maps a raw ADC reading to key 1..6 or none.
// Depends on alkd_pkg for the configuration struct and widths.
module alkd_decode
    import alkd_pkg::*;
(
    input  logic [RAW_W-1:0] i_raw,
    input  t_cfg             i_cfg,
    output logic [KEY_W-1:0] o_key
);

    // First threshold at or above the reading wins; above release means none
    always_comb begin
        o_key = KEY_NONE;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (i_raw <= i_cfg.key_max[k]) begin
                o_key = KEY_W'(k + 1);
            end
        end
        if (i_raw > i_cfg.release_thr) begin
            o_key = KEY_NONE;
        end
    end

endmodule

// ===== hw/rtl/alkd_core.sv =====
// Input register, sample gating, debounce state and result register.
// Depends on alkd_pkg and instantiates alkd_decode.
module alkd_core
    import alkd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Pipeline registers
    logic      r_s1_valid;
    t_in_item  r_s1_data;
    logic      r_out_valid;
    t_out_item r_out_data;

    // Debounce state
    logic [TIME_W-1:0] r_last_time, n_last_time;
    logic [RAW_W-1:0]  r_last_raw,  n_last_raw;
    logic [KEY_W-1:0]  r_cand_key,  n_cand_key;
    logic [TIME_W-1:0] r_cand_since, n_cand_since;
    logic [KEY_W-1:0]  r_deb_key,   n_deb_key;
    t_out_item         n_out;

    logic              adv;
    logic              fire;
    logic [KEY_W-1:0]  dec_key;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] cand_age;

    // Handshake: the result register empties or is taken, so stage 1 moves
    assign adv        = !r_out_valid || i_out_ready;
    assign fire       = adv && r_s1_valid;
    assign o_in_ready = !r_s1_valid || adv;

    alkd_decode u_decode (
        .i_raw (r_s1_data.raw_sample),
        .i_cfg (i_cfg),
        .o_key (dec_key)
    );

    assign elapsed  = r_s1_data.now_ms - r_last_time;
    assign cand_age = r_s1_data.now_ms - r_cand_since;

    // Next state and result for the transaction in stage 1
    always_comb begin
        n_last_time  = r_last_time;
        n_last_raw   = r_last_raw;
        n_cand_key   = r_cand_key;
        n_cand_since = r_cand_since;
        n_deb_key    = r_deb_key;
        n_out.press_valid = 1'b0;
        n_out.press_key   = KEY_NONE;
        n_out.press_raw   = '0;
        if (elapsed >= SAMPLE_INTERVAL_MS) begin
            n_last_time = r_s1_data.now_ms;
            n_last_raw  = r_s1_data.raw_sample;
            if (dec_key != r_cand_key) begin
                n_cand_key   = dec_key;
                n_cand_since = r_s1_data.now_ms;
            end else if (dec_key != r_deb_key &&
                         cand_age >= TIME_W'(i_cfg.debounce_ms)) begin
                n_deb_key = dec_key;
                if (dec_key != KEY_NONE) begin
                    n_out.press_valid = 1'b1;
                    n_out.press_key   = dec_key;
                    n_out.press_raw   = r_s1_data.raw_sample;
                end
            end
        end
        n_out.stable_key = n_deb_key;
        n_out.held_raw   = n_last_raw;
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_time  <= '0;
            r_last_raw   <= '0;
            r_cand_key   <= KEY_NONE;
            r_cand_since <= '0;
            r_deb_key    <= KEY_NONE;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (fire) begin
                r_last_time  <= n_last_time;
                r_last_raw   <= n_last_raw;
                r_cand_key   <= n_cand_key;
                r_cand_since <= n_cand_since;
                r_deb_key    <= n_deb_key;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_data <= i_in_data;
        end
        if (fire) begin
            r_out_data <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hw/rtl/analog_ladder_keypad_debouncer_top.sv =====
// Top level of the analog ladder keypad debouncer.
// Depends on alkd_pkg; instantiates alkd_cfg_regs and alkd_core.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one
// transaction per ADC reading: a millisecond timestamp and the raw value.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns one
// transaction per input: stable key, last accepted reading and a press
// pulse with key and reading when a new nonzero key settles.
// Readings closer than the sample interval to the last accepted one are
// ignored but still produce a result with unchanged state.
// The input register loads at the accepting edge and the result register
// once stage 1 moves on, after which the result is valid.
// Throughput: one transaction per cycle unless stalled; the whole decode
// and debounce update is one pass of logic from input to result register.
// Reset (i_rst_n low, synchronous) loads the threshold defaults, clears
// all debounce state and empties both pipeline registers.
// On a receiver stall the result is held and the input register still
// takes one more transaction; then o_in_ready drops. Configuration writes
// take effect at once; the user must make them while idle (not enforced).
module analog_ladder_keypad_debouncer_top
    import alkd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    t_cfg cfg;

    alkd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    alkd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for analog_ladder_keypad_debouncer_top.
// Depends on alkd_pkg and the RTL under hw/rtl; predicts each result in a
// scoreboard class and drives both valid/ready channels with random stalls.
module tb;
    import alkd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 160;

    // Tracks threshold/debounce state and holds the reports still owed by the DUT
    class keypad_scoreboard;
        logic [RAW_W-1:0]  key_max [NUM_KEYS];
        logic [RAW_W-1:0]  release_thr;
        logic [DEB_W-1:0]  debounce_ms;
        logic [TIME_W-1:0] last_time;
        logic [TIME_W-1:0] cand_since;
        logic [RAW_W-1:0]  last_raw;
        logic [KEY_W-1:0]  cand_key;
        logic [KEY_W-1:0]  settled_key;
        t_out_item         awaited_reports[$];
        int                errors;

        function new();
            key_max[0]  = KEY1_MAX_RST;
            key_max[1]  = KEY2_MAX_RST;
            key_max[2]  = KEY3_MAX_RST;
            key_max[3]  = KEY4_MAX_RST;
            key_max[4]  = KEY5_MAX_RST;
            key_max[5]  = KEY6_MAX_RST;
            release_thr = RELEASE_THR_RST;
            debounce_ms = DEBOUNCE_MS_RST;
            last_time   = '0;
            cand_since  = '0;
            last_raw    = '0;
            cand_key    = KEY_NONE;
            settled_key = KEY_NONE;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RELEASE_THR: release_thr = data[RAW_W-1:0];
                REG_DEBOUNCE_MS: debounce_ms = data[DEB_W-1:0];
                default:         key_max[idx - REG_KEY1_MAX] = data[RAW_W-1:0];
            endcase
        endfunction

        // Ladder decode: above release is none, else first threshold at or above
        function logic [KEY_W-1:0] decode_key(logic [RAW_W-1:0] raw);
            if (raw > release_thr) return KEY_NONE;
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (raw <= key_max[k]) return KEY_W'(k + 1);
            end
            return KEY_NONE;
        endfunction

        function int pending();
            return awaited_reports.size();
        endfunction

        // Accepted input transaction: update debounce state, queue the report
        function void note_reading(t_in_item rd);
            t_out_item         rep;
            logic [KEY_W-1:0]  key;
            logic [TIME_W-1:0] since_last;
            logic [TIME_W-1:0] held_for;
            rep = '0;
            since_last = rd.now_ms - last_time;
            if (since_last >= SAMPLE_INTERVAL_MS) begin
                last_time = rd.now_ms;
                last_raw  = rd.raw_sample;
                key       = decode_key(rd.raw_sample);
                held_for  = rd.now_ms - cand_since;
                if (key != cand_key) begin
                    cand_key   = key;
                    cand_since = rd.now_ms;
                end else if (key != settled_key && held_for >= {16'd0, debounce_ms}) begin
                    settled_key = key;
                    if (key != KEY_NONE) begin
                        rep.press_valid = 1'b1;
                        rep.press_key   = key;
                        rep.press_raw   = rd.raw_sample;
                    end
                end
            end
            rep.stable_key = settled_key;
            rep.held_raw   = last_raw;
            awaited_reports.push_back(rep);
        endfunction

        // Accepted output transaction: compare with the oldest queued report
        function void check_report(t_out_item got);
            t_out_item exp;
            if (awaited_reports.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = awaited_reports.pop_front();
            if (got.stable_key !== exp.stable_key) begin
                $display("%0t: stable_key expected %0d got %0d", $time,
                         exp.stable_key, got.stable_key);
                errors++;
            end
            if (got.held_raw !== exp.held_raw) begin
                $display("%0t: held_raw expected %0d got %0d", $time,
                         exp.held_raw, got.held_raw);
                errors++;
            end
            if (got.press_valid !== exp.press_valid) begin
                $display("%0t: press_valid expected %0d got %0d", $time,
                         exp.press_valid, got.press_valid);
                errors++;
            end
            if (got.press_key !== exp.press_key) begin
                $display("%0t: press_key expected %0d got %0d", $time,
                         exp.press_key, got.press_key);
                errors++;
            end
            if (got.press_raw !== exp.press_raw) begin
                $display("%0t: press_raw expected %0d got %0d", $time,
                         exp.press_raw, got.press_raw);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;

    keypad_scoreboard  sb = new();
    logic              quiet = 1'b0;
    logic [TIME_W-1:0] t_ms;
    int                step_max;
    int unsigned       cycle_count = 0;

    analog_ladder_keypad_debouncer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_report(o_out_data);
    end

    // Receiver: random stall bursts, none once quiet
    initial begin : out_stall
        int n;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 18);
                repeat (n) begin
                    @(negedge i_clk);
                    i_out_ready = 1'b0;
                end
            end
            n = $urandom_range(1, 30);
            repeat (n) begin
                @(negedge i_clk);
                i_out_ready = 1'b1;
            end
        end
    end

    function automatic int next_gap();
        if (!quiet && $urandom_range(0, 5) == 0) return $urandom_range(1, 18);
        return 0;
    endfunction

    // One input transaction, with an optional idle burst ahead of it
    task automatic send_reading(input logic [TIME_W-1:0] t, input logic [RAW_W-1:0] raw);
        int gap;
        gap = next_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data.now_ms     = t;
        i_in_data.raw_sample = raw;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_reading(i_in_data);
    endtask

    // Stop sending and let every queued report come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic load_setting(input logic [CFG_DATA_W-1:0] k1, k2, k3, k4, k5, k6,
                                input logic [CFG_DATA_W-1:0] rel, deb);
        write_reg(REG_KEY1_MAX, k1);
        write_reg(REG_KEY2_MAX, k2);
        write_reg(REG_KEY3_MAX, k3);
        write_reg(REG_KEY4_MAX, k4);
        write_reg(REG_KEY5_MAX, k5);
        write_reg(REG_KEY6_MAX, k6);
        write_reg(REG_RELEASE_THR, rel);
        write_reg(REG_DEBOUNCE_MS, deb);
    endtask

    // Ascending thresholds with random spacing, random debounce
    task automatic load_ordered(input int deb_max);
        logic [CFG_DATA_W-1:0] v [7];
        v[0] = CFG_DATA_W'($urandom_range(0, 500));
        for (int i = 1; i < 7; i++) v[i] = v[i-1] + CFG_DATA_W'($urandom_range(1, 500));
        load_setting(v[0], v[1], v[2], v[3], v[4], v[5], v[6],
                     CFG_DATA_W'($urandom_range(0, deb_max)));
    endtask

    task automatic apply_setting(input int phase);
        case (phase)
            0: step_max = 12;   // reset defaults
            1: begin            // no debounce at all
                load_setting(100, 400, 900, 1500, 2200, 3000, 3500, 0);
                step_max = 10;
            end
            2: begin            // all thresholds at zero, longest debounce
                load_setting(0, 0, 0, 0, 0, 0, 0, 16'hFFFF);
                step_max = 40000;
            end
            3: begin            // all thresholds at full scale
                load_setting(16'hFFF, 16'hFFF, 16'hFFF, 16'hFFF, 16'hFFF, 16'hFFF,
                             16'hFFF, 1);
                step_max = 8;
            end
            4: begin            // unordered thresholds, upper write bits set at random
                load_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                             CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                             CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                             CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 60)));
                step_max = 15;
            end
            5: begin
                load_ordered(80);
                step_max = 12;
            end
            6: begin
                load_ordered(200);
                step_max = 25;
            end
            default: begin      // back to defaults, written explicitly
                load_setting(CFG_DATA_W'(KEY1_MAX_RST), CFG_DATA_W'(KEY2_MAX_RST),
                             CFG_DATA_W'(KEY3_MAX_RST), CFG_DATA_W'(KEY4_MAX_RST),
                             CFG_DATA_W'(KEY5_MAX_RST), CFG_DATA_W'(KEY6_MAX_RST),
                             CFG_DATA_W'(RELEASE_THR_RST), DEBOUNCE_MS_RST);
                step_max = 12;
            end
        endcase
    endtask

    // Reading that lands at or just under the threshold of the wanted key
    function automatic logic [RAW_W-1:0] reading_for(input logic [KEY_W-1:0] key);
        logic [RAW_W-1:0] top;
        logic [RAW_W-1:0] off;
        off = RAW_W'($urandom_range(0, 3));
        if (key == KEY_NONE) return 12'hFFF - off;
        top = sb.key_max[key - 1];
        return (top > off) ? top - off : '0;
    endfunction

    // Held key presses with random content, early samples, jumps and noise
    task automatic run_random(input int n);
        int               hold;
        logic [KEY_W-1:0] target;
        logic [TIME_W-1:0] dt;
        logic [RAW_W-1:0] raw;
        hold   = 0;
        target = KEY_NONE;
        repeat (n) begin
            if (hold == 0) begin
                target = KEY_W'($urandom_range(0, NUM_KEYS));
                hold   = $urandom_range(1, 12);
            end
            hold--;
            case ($urandom_range(0, 19))
                0, 1:    dt = $urandom_range(0, 4);
                2:       dt = $urandom;
                default: dt = $urandom_range(5, step_max);
            endcase
            t_ms = t_ms + dt;
            if ($urandom_range(0, 9) == 0) raw = RAW_W'($urandom_range(0, 4095));
            else raw = reading_for(target);
            send_reading(t_ms, raw);
            if ($urandom_range(0, 99) == 0) wait_idle();
        end
    endtask

    // Directed walk through every key at default thresholds, early samples, wrap
    task automatic run_directed();
        send_reading(32'd0, 12'd0);         // no time passed since reset
        send_reading(32'd4, 12'hFFF);       // still too early
        send_reading(32'd5, 12'd0);         // key 1 becomes candidate
        send_reading(32'd20, 12'd300);      // not held long enough
        send_reading(32'd35, 12'd300);      // key 1 press
        send_reading(32'd40, 12'd301);      // key 2 candidate
        send_reading(32'd44, 12'hFFF);      // too early, ignored
        send_reading(32'd70, 12'd800);      // key 2 press
        send_reading(32'd75, 12'd801);
        send_reading(32'd105, 12'd1400);    // key 3 press
        send_reading(32'd110, 12'd1401);
        send_reading(32'd140, 12'd2000);    // key 4 press
        send_reading(32'd145, 12'd2001);
        send_reading(32'd175, 12'd2600);    // key 5 press
        send_reading(32'd180, 12'd2601);
        send_reading(32'd210, 12'd3200);    // key 6 press
        send_reading(32'd215, 12'd3201);    // gap between key 6 and release
        send_reading(32'd245, 12'd3700);    // stable key drops to none, no press
        send_reading(32'd250, 12'd3701);    // above release
        send_reading(32'hFFFF_FFF0, 12'd2000);
        send_reading(32'hFFFF_FFFF, 12'd1500);
        send_reading(32'h0000_000E, 12'd1999);  // press across the time wrap
        send_reading(32'h0000_0013, 12'hFFF);
        t_ms = 32'h0000_0013;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx   = REG_KEY1_MAX;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            if (phase == NUM_PHASES - 1) quiet = 1'b1;
            apply_setting(phase);
            run_random(PHASE_ITEMS);
        end
        wait_idle();
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
